// File: hw/rtl/mppt_pkg.sv
// Shared constants for the mouse packet position tracker.
`default_nettype none

package mppt_pkg;

  // Widths fixed by the interface.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FIELD_W = 12;

  // Default coordinate width of the cursor registers.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Bit positions inside the head byte.
  localparam int unsigned ALIGN_BIT  = 3;
  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_RIGHT  = 1;
  localparam int unsigned BTN_MIDDLE = 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 1'd1;

  // Reset values.
  localparam logic [FIELD_W-1:0] X_LIMIT_RESET = 12'd799;
  localparam logic [FIELD_W-1:0] Y_LIMIT_RESET = 12'd599;
  localparam int unsigned X_START = 400;
  localparam int unsigned Y_START = 300;

endpackage

`default_nettype wire

// File: hw/rtl/mouse_packet_position_tracker.sv
// Mouse packet position tracker: packet assembly, cursor update and result register.
// The result of a packet is on out_valid in the cycle after its third byte transfers.
// One byte per cycle is taken while in_stall is low; add-and-clamp logic sits before the result register.
// A completed packet waits only while the result register is still held by out_stall.
// Synchronous active-low reset: phase 0, cursor at (400, 300), limits 799 and 599,
// result register empty.
`default_nettype none

module mouse_packet_position_tracker #(
  parameter int unsigned COORD_BITS = mppt_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input channel.
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [mppt_pkg::BYTE_W-1:0]        in_rx_byte,
  // Result channel.
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mppt_pkg::FIELD_W-1:0]            out_pos_x,
  output logic [mppt_pkg::FIELD_W-1:0]            out_pos_y,
  output logic                                    out_left_pressed,
  output logic                                    out_right_pressed,
  output logic                                    out_middle_pressed,
  // Configuration port.
  input  wire logic                               cfg_wr_en,
  input  wire logic [mppt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mppt_pkg::FIELD_W-1:0]       cfg_data
);

  localparam int unsigned FW = mppt_pkg::FIELD_W;
  localparam int unsigned BW = mppt_pkg::BYTE_W;
  // Signed working width: holds the wider of coordinate and limit plus sign and carry.
  localparam int unsigned SW = ((COORD_BITS > FW) ? COORD_BITS : FW) + 2;

  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_DX   = 2'd1;
  localparam logic [1:0] PH_DY   = 2'd2;

  localparam logic [SW-1:0] COORD_MAX = SW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [COORD_BITS-1:0] X_RST = COORD_BITS'(mppt_pkg::X_START);
  localparam logic [COORD_BITS-1:0] Y_RST = COORD_BITS'(mppt_pkg::Y_START);

  logic [1:0]            phase_r, phase_nxt;
  logic [BW-1:0]         head_r, head_nxt;
  logic [BW-1:0]         dx_r, dx_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [FW-1:0]         x_limit_r, y_limit_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [FW-1:0]         pos_x_r, pos_y_r;
  logic                  left_r, right_r, middle_r;

  logic                  in_xfer, out_xfer, pkt_done;
  logic signed [SW-1:0]  sum_x, sum_y;
  logic [SW-1:0]         lim_x, lim_y;
  logic [SW-1:0]         clamp_x, clamp_y;

  // A completing packet needs the result register free (or emptying this cycle).
  assign in_stall = (phase_r == PH_DY) && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign pkt_done = in_xfer && (phase_r == PH_DY);

  // Limits wider than the coordinate saturate to its largest value.
  always_comb begin
    lim_x = (SW'(x_limit_r) > COORD_MAX) ? COORD_MAX : SW'(x_limit_r);
    lim_y = (SW'(y_limit_r) > COORD_MAX) ? COORD_MAX : SW'(y_limit_r);
  end

  // Y grows downward, so the Y delta is subtracted.
  always_comb begin
    sum_x = $signed(SW'(cur_x_r)) + SW'($signed(dx_r));
    sum_y = $signed(SW'(cur_y_r)) - SW'($signed(in_rx_byte));
    if (sum_x < 0) begin
      clamp_x = '0;
    end else if ($unsigned(sum_x) > lim_x) begin
      clamp_x = lim_x;
    end else begin
      clamp_x = $unsigned(sum_x);
    end
    if (sum_y < 0) begin
      clamp_y = '0;
    end else if ($unsigned(sum_y) > lim_y) begin
      clamp_y = lim_y;
    end else begin
      clamp_y = $unsigned(sum_y);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    head_nxt  = head_r;
    dx_nxt    = dx_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (in_xfer) begin
      case (phase_r)
        PH_DX: begin
          dx_nxt    = in_rx_byte;
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          cur_x_nxt = clamp_x[COORD_BITS-1:0];
          cur_y_nxt = clamp_y[COORD_BITS-1:0];
          phase_nxt = PH_HEAD;
        end
        default: begin
          // Looking for a head byte; one without the alignment bit is dropped.
          if (in_rx_byte[mppt_pkg::ALIGN_BIT]) begin
            head_nxt  = in_rx_byte;
            phase_nxt = PH_DX;
          end else begin
            phase_nxt = PH_HEAD;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pkt_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      head_r      <= '0;
      dx_r        <= '0;
      cur_x_r     <= X_RST;
      cur_y_r     <= Y_RST;
      x_limit_r   <= mppt_pkg::X_LIMIT_RESET;
      y_limit_r   <= mppt_pkg::Y_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      head_r      <= head_nxt;
      dx_r        <= dx_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          mppt_pkg::CFG_X_LIMIT: x_limit_r <= cfg_data;
          mppt_pkg::CFG_Y_LIMIT: y_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result payload; it loads only on a completed packet, which never lands on a held result.
  always_ff @(posedge clk) begin
    if (pkt_done) begin
      pos_x_r  <= clamp_x[FW-1:0];
      pos_y_r  <= clamp_y[FW-1:0];
      left_r   <= head_r[mppt_pkg::BTN_LEFT];
      right_r  <= head_r[mppt_pkg::BTN_RIGHT];
      middle_r <= head_r[mppt_pkg::BTN_MIDDLE];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pos_x          = pos_x_r;
  assign out_pos_y          = pos_y_r;
  assign out_left_pressed   = left_r;
  assign out_right_pressed  = right_r;
  assign out_middle_pressed = middle_r;

  // The input is held back only for a third byte facing a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && phase_r == PH_DY))
    else $error("input stalled without a blocked packet result");

  // Every transfer of a third byte produces a result in the cycle after it.
  a_pkt_result: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_done |=> (out_valid_r && phase_r == PH_HEAD))
    else $error("completed packet did not produce a result");

  // A pending result does not exceed the configured limits unless they are lowered while it is pending.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pos_x <= x_limit_r && out_pos_y <= y_limit_r))
    else $error("cursor position beyond its limit");

endmodule

`default_nettype wire
